FILE: hdl/range_max_segment_tree_defines.svh
// Assertion macros shared by the range-max segment tree checkers.
// Relies on clk and rst_n being visible where a macro is used.
`ifndef RANGE_MAX_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_DEFINES_SVH

// same-cycle implication
`define RMST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rmst_pkg.sv
// Package for the range-max segment tree: sizes, codes, and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package rmst_pkg;

    localparam int LEAVES  = 1024;
    localparam int NODES   = 2 * LEAVES;
    localparam int NODE_W  = $clog2(NODES);
    localparam int BOUND_W = NODE_W + 1;
    localparam int DATA_W  = 32;
    localparam int LEAF_W  = 10;
    localparam int RANGE_W = 11;

    localparam logic signed [DATA_W-1:0] NODE_RESET = -32'sd1000000000;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic leaf_write;
        logic a_read;
        logic a_write;
        logic q_left_read;
        logic q_left_acc;
        logic q_right_read;
        logic q_right_acc;
        logic q_shift;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic leaf_ok;
        logic at_root;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
        logic out_free;
    } status_t;

    function automatic logic signed [DATA_W-1:0] smax(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rmst_ctrl.sv
// Sequencer for the range-max segment tree: clear sweep, leaf assign walk,
// and range query walk. Depends on rmst_pkg.
`default_nettype none

module rmst_ctrl
    import rmst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    kind,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         in_stall
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_READ,
        S_A_WRITE,
        S_Q_LEFT,
        S_Q_LWAIT,
        S_Q_RIGHT,
        S_Q_RWAIT,
        S_Q_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (kind == KIND_QUERY)
                    begin
                        state_next = S_Q_LEFT;
                    end
                    else if (status.leaf_ok)
                    begin
                        cmd.leaf_write = 1'b1;
                        state_next     = S_A_READ;
                    end
                end
            end
            S_A_READ:
            begin
                cmd.a_read = 1'b1;
                state_next = S_A_WRITE;
            end
            S_A_WRITE:
            begin
                cmd.a_write = 1'b1;
                state_next  = status.at_root ? S_IDLE : S_A_READ;
            end
            S_Q_LEFT:
            begin
                if (!status.l_lt_r)
                begin
                    state_next = S_Q_DONE;
                end
                else if (status.l_odd)
                begin
                    cmd.q_left_read = 1'b1;
                    state_next      = S_Q_LWAIT;
                end
                else
                begin
                    state_next = S_Q_RIGHT;
                end
            end
            S_Q_LWAIT:
            begin
                cmd.q_left_acc = 1'b1;
                state_next     = S_Q_RIGHT;
            end
            S_Q_RIGHT:
            begin
                if (status.r_odd)
                begin
                    cmd.q_right_read = 1'b1;
                    state_next       = S_Q_RWAIT;
                end
                else
                begin
                    cmd.q_shift = 1'b1;
                    state_next  = S_Q_LEFT;
                end
            end
            S_Q_RWAIT:
            begin
                cmd.q_right_acc = 1'b1;
                cmd.q_shift     = 1'b1;
                state_next      = S_Q_LEFT;
            end
            S_Q_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/rmst_dpath.sv
// Datapath for the range-max segment tree: node RAM, walk registers,
// max unit and result register. Depends on rmst_pkg.
`default_nettype none

module rmst_dpath
    import rmst_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    input  wire logic [LEAF_W-1:0]         leaf_index,
    input  wire logic signed [DATA_W-1:0]  new_value,
    input  wire logic [RANGE_W-1:0]        range_start,
    input  wire logic [RANGE_W-1:0]        range_end,
    input  wire logic                      out_stall,
    output status_t                        status,
    output logic                           out_valid,
    output logic signed [DATA_W-1:0]       range_max
);

    logic signed [DATA_W-1:0] mem [NODES];
    logic signed [DATA_W-1:0] rdata_reg;

    logic [NODE_W-1:0]        clr_cnt_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] range_max_reg;
    logic [NODE_W-1:0]        node_reg;
    logic signed [DATA_W-1:0] cur_reg;
    logic [BOUND_W-1:0]       l_reg;
    logic [BOUND_W-1:0]       r_reg;
    logic signed [DATA_W-1:0] best_reg;
    logic                     any_reg;

    logic [NODE_W-1:0]        leaf_node;
    logic [NODE_W-1:0]        parent;
    logic [BOUND_W-1:0]       r_dec;
    logic [RANGE_W-1:0]       start_clamp;
    logic [RANGE_W-1:0]       end_clamp;
    logic signed [DATA_W-1:0] up_max;
    logic signed [DATA_W-1:0] best_next;
    logic                     we;
    logic [NODE_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [NODE_W-1:0]        raddr;

    assign leaf_node   = NODE_W'(LEAVES) + NODE_W'(leaf_index);
    assign parent      = node_reg >> 1;
    assign r_dec       = r_reg - BOUND_W'(1);
    assign start_clamp = (range_start > RANGE_W'(LEAVES)) ? RANGE_W'(LEAVES) : range_start;
    assign end_clamp   = (range_end > RANGE_W'(LEAVES)) ? RANGE_W'(LEAVES) : range_end;
    assign up_max      = smax(cur_reg, rdata_reg);
    assign best_next   = any_reg ? smax(best_reg, rdata_reg) : rdata_reg;

    assign status.clear_last = (clr_cnt_reg == NODE_W'(NODES - 1));
    assign status.leaf_ok    = ({1'b0, leaf_index} < (LEAF_W + 1)'(LEAVES));
    assign status.at_root    = (parent == NODE_W'(1));
    assign status.l_lt_r     = (l_reg < r_reg);
    assign status.l_odd      = l_reg[0];
    assign status.r_odd      = r_reg[0];
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign range_max = range_max_reg;

    always_comb
    begin
        we    = 1'b1;
        waddr = parent;
        wdata = up_max;
        if (cmd.clear_step)
        begin
            waddr = clr_cnt_reg;
            wdata = NODE_RESET;
        end
        else if (cmd.leaf_write)
        begin
            waddr = leaf_node;
            wdata = new_value;
        end
        else if (!cmd.a_write)
        begin
            we = 1'b0;
        end
    end

    always_comb
    begin
        re    = cmd.a_read || cmd.q_left_read || cmd.q_right_read;
        raddr = node_reg ^ NODE_W'(1);
        if (cmd.q_left_read)
        begin
            raddr = l_reg[NODE_W-1:0];
        end
        else if (cmd.q_right_read)
        begin
            raddr = r_dec[NODE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            node_reg <= leaf_node;
            cur_reg  <= new_value;
            l_reg    <= BOUND_W'(start_clamp) + BOUND_W'(LEAVES);
            r_reg    <= BOUND_W'(end_clamp) + BOUND_W'(LEAVES);
            best_reg <= '0;
            any_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.a_write)
            begin
                node_reg <= parent;
                cur_reg  <= up_max;
            end
            if (cmd.q_left_acc || cmd.q_right_acc)
            begin
                best_reg <= best_next;
                any_reg  <= 1'b1;
            end
            if (cmd.q_left_acc)
            begin
                l_reg <= l_reg + BOUND_W'(1);
            end
            else if (cmd.q_shift)
            begin
                l_reg <= l_reg >> 1;
            end
            if (cmd.q_right_read)
            begin
                r_reg <= r_dec;
            end
            else if (cmd.q_shift)
            begin
                r_reg <= r_reg >> 1;
            end
        end
        if (cmd.out_load)
        begin
            range_max_reg <= best_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/range_max_segment_tree.sv
// Range-max segment tree over 1024 signed 32-bit leaves with point assign.
// After reset the block sweeps its 2048-node RAM to -1000000000 and takes no
// request until done. One request at a time: an assign makes one leaf write,
// then a sibling read and a parent write per level on the single-read-port
// node RAM; a query reads each node that it folds in through the same port.
// A finished result waits in the output register while the next request runs.
// Depends on rmst_pkg, rmst_ctrl and rmst_dpath.
`default_nettype none

module range_max_segment_tree
    import rmst_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      kind,
    input  wire logic [LEAF_W-1:0]         leaf_index,
    input  wire logic signed [DATA_W-1:0]  new_value,
    input  wire logic [RANGE_W-1:0]        range_start,
    input  wire logic [RANGE_W-1:0]        range_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [DATA_W-1:0]       range_max
);

    cmd_t    cmd;
    status_t status;

    rmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    rmst_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .leaf_index  (leaf_index),
        .new_value   (new_value),
        .range_start (range_start),
        .range_end   (range_end),
        .out_stall   (out_stall),
        .status      (status),
        .out_valid   (out_valid),
        .range_max   (range_max)
    );

endmodule

`default_nettype wire

FILE: hdl/rmst_checker.sv
// Port-level checks for the range-max segment tree, bound to the top level.
// Depends on rmst_pkg and range_max_segment_tree_defines.svh.
`default_nettype none

`include "range_max_segment_tree_defines.svh"

module rmst_checker
    import rmst_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      kind,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [DATA_W-1:0]  range_max
);

    `RMST_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(range_max), "stalled result changed or dropped")

    `RMST_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (kind == KIND_QUERY),
        in_stall, "query request did not occupy the block")

    `RMST_ASSERT_IMPL(a_result_from_work, $rose(out_valid),
        $past(in_stall), "result appeared while the block was idle")

endmodule

bind range_max_segment_tree rmst_checker u_rmst_checker (.*);

`default_nettype wire

FILE: tb/range_max_segment_tree_tb.sv
`timescale 1ns / 100ps
// Testbench for range_max_segment_tree: directed and random assign/query requests
// checked against a leaf-array predictor of the range maximum. Depends on rmst_pkg.

module range_max_segment_tree_tb;
    import rmst_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 60;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind = KIND_ASSIGN;
    logic [LEAF_W-1:0]         leaf_index = '0;
    logic signed [DATA_W-1:0]  new_value = '0;
    logic [RANGE_W-1:0]        range_start = '0;
    logic [RANGE_W-1:0]        range_end = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DATA_W-1:0]  range_max;

    logic signed [DATA_W-1:0]  leaf_values [LEAVES];
    logic signed [DATA_W-1:0]  expected_max [$];
    int                        mismatches = 0;
    int                        cycle_count = 0;
    bit                        sender_idling = 1'b1;
    logic                      recv_idling = 1'b1;
    logic                      hold_results = 1'b0;

    range_max_segment_tree i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .leaf_index  (leaf_index),
        .new_value   (new_value),
        .range_start (range_start),
        .range_end   (range_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .range_max   (range_max)
    );

    always #6 clk = ~clk;

    function automatic logic signed [DATA_W-1:0] range_maximum(
        input logic [RANGE_W-1:0] first,
        input logic [RANGE_W-1:0] stop
    );
        int                       lo;
        int                       hi;
        logic signed [DATA_W-1:0] best;
        lo = (first > LEAVES) ? LEAVES : int'(first);
        hi = (stop > LEAVES) ? LEAVES : int'(stop);
        if (lo >= hi)
            return '0;
        best = leaf_values[lo];
        for (int i = lo + 1; i < hi; i++)
            if (leaf_values[i] > best)
                best = leaf_values[i];
        return best;
    endfunction

    task automatic send_request(
        input logic                     k,
        input logic [LEAF_W-1:0]        idx,
        input logic signed [DATA_W-1:0] val,
        input logic [RANGE_W-1:0]       first,
        input logic [RANGE_W-1:0]       stop
    );
        while (sender_idling && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        leaf_index  <= idx;
        new_value   <= val;
        range_start <= first;
        range_end   <= stop;
        do
            @(posedge clk);
        while (in_stall);
        if (k == KIND_QUERY)
            expected_max = {expected_max, range_maximum(first, stop)};
        else
            leaf_values[idx] = val;
    endtask

    task automatic send_assign(input logic [LEAF_W-1:0] idx, input logic signed [DATA_W-1:0] val);
        send_request(KIND_ASSIGN, idx, val, RANGE_W'($urandom), RANGE_W'($urandom));
    endtask

    task automatic send_query(input logic [RANGE_W-1:0] first, input logic [RANGE_W-1:0] stop);
        send_request(KIND_QUERY, LEAF_W'($urandom), DATA_W'($urandom), first, stop);
    endtask

    task automatic test_reset_state();
        send_query(0, 1024);
        send_query(7, 8);
        send_query(5, 5);
        send_query(10, 3);
        send_query(2047, 2047);
        send_query(0, 2047);
    endtask

    task automatic test_extremes();
        send_assign(0, 32'sh8000_0000);
        send_assign(1023, 32'sh7fff_ffff);
        send_assign(512, 0);
        send_assign(513, -1);
        send_query(0, 1);
        send_query(1023, 1024);
        send_query(1023, 2047);
        send_query(0, 1024);
        send_query(1024, 2047);
        send_query(1, 1023);
        send_query(512, 514);
    endtask

    task automatic test_point_queries();
        send_assign(300, NODE_RESET - 1);
        send_assign(301, NODE_RESET + 1);
        send_query(300, 301);
        send_query(301, 302);
        send_query(299, 302);
    endtask

    task automatic random_request();
        logic [LEAF_W-1:0]        idx;
        logic signed [DATA_W-1:0] val;
        logic [RANGE_W-1:0]       first;
        logic [RANGE_W-1:0]       stop;
        int                       sel;
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            case ($urandom_range(6))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7fff_ffff;
                2: val = 0;
                3: val = -1;
                4: val = NODE_RESET;
                5: val = NODE_RESET - 1;
                default: val = NODE_RESET + 1;
            endcase
        end
        else if (sel < 40)
            val = $signed($urandom_range(2000)) - 1000;
        else
            val = $urandom;
        idx = ($urandom_range(99) < 70) ? LEAF_W'($urandom_range(63)) : LEAF_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            first = RANGE_W'($urandom_range(63));
            stop  = first + RANGE_W'($urandom_range(20));
        end
        else if (sel < 75)
        begin
            first = RANGE_W'($urandom_range(1023));
            stop  = first + RANGE_W'($urandom_range(40));
        end
        else if (sel < 90)
        begin
            first = RANGE_W'($urandom_range(2047));
            stop  = RANGE_W'($urandom_range(2047));
        end
        else
        begin
            first = RANGE_W'($urandom_range(3));
            stop  = RANGE_W'($urandom_range(2047, 1020));
        end
        if ($urandom_range(99) < 45)
            send_assign(idx, val);
        else
            send_query(first, stop);
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++)
        begin
            sender_idling = !(n >= 200 && n < 350);
            recv_idling  <= !(n >= 200 && n < 350);
            random_request();
        end
        sender_idling = 1'b1;
        recv_idling  <= 1'b1;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_results <= 1'b1;
                repeat (300) @(posedge clk);
                hold_results <= 1'b0;
            end
            begin
                sender_idling = 1'b0;
                for (int n = 0; n < 12; n++)
                begin
                    if (n % 3 == 0)
                        send_assign(LEAF_W'($urandom_range(63)), $urandom);
                    else
                        send_query(RANGE_W'($urandom_range(31)),
                            RANGE_W'($urandom_range(64, 20)));
                end
                sender_idling = 1'b1;
            end
        join
    endtask

    always @(posedge clk)
    begin : check_results
        logic signed [DATA_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_max.size() == 0)
            begin
                $error("range_max: expected none, got %0d", range_max);
                mismatches++;
            end
            else
            begin
                want = expected_max.pop_front();
                if (range_max !== want)
                begin
                    $error("range_max: expected %0d, got %0d", want, range_max);
                    mismatches++;
                end
            end
        end
        out_stall <= hold_results || (recv_idling && $urandom_range(99) < 6);
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("range_max_segment_tree: mismatch");
        $finish;
    end

    initial
    begin
        foreach (leaf_values[i])
            leaf_values[i] = NODE_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_extremes();
        test_point_queries();
        test_backpressure();
        test_random_mix(650);
        in_valid <= 1'b0;
        while (expected_max.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_max.size() == 0)
            $display("range_max_segment_tree: match");
        else
            $display("range_max_segment_tree: mismatch");
        $finish;
    end

endmodule
